// File: rtl/lds_pkg.sv
// Shared types and fixed-point helpers for the 3x3 LDL^T solver.
// Holds the input and result word layouts and the saturating Q-format arithmetic.
// Depends on nothing; every other file imports it.
package lds_pkg;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t a00;
    q_t a10;
    q_t a20;
    q_t a11;
    q_t a21;
    q_t a22;
    q_t rhs0;
    q_t rhs1;
    q_t rhs2;
  } in_word_t;

  typedef struct packed {
    q_t   sol0;
    q_t   sol1;
    q_t   sol2;
    logic bad_pivot;
  } out_word_t;

  localparam logic signed [63:0] MaxQ = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] MinQ = -64'sh0000_0000_8000_0000;

  // clamp a wide signed value into the 32-bit range
  function automatic q_t sat64(input logic signed [63:0] v);
    q_t r;
    if (v > MaxQ) begin
      r = 32'sh7fff_ffff;
    end else if (v < MinQ) begin
      r = -32'sh8000_0000;
    end else begin
      r = q_t'(v[31:0]);
    end
    return r;
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [63:0] d;
    d = 64'(a) - 64'(b);
    return sat64(d);
  endfunction

  // product, round half up, floor shift, saturate
  function automatic q_t qmul(input q_t a, input q_t b, input int frac);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + (64'sd1 <<< (frac - 1));
    p = p >>> frac;
    return sat64(p);
  endfunction

endpackage

// File: rtl/lds_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// One quotient bit per stage, several lanes share one positive divisor.
// Depends on lds_pkg.
module lds_div
  import lds_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int LANES     = 1,
  parameter int TAG_W     = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [LANES-1:0][31:0] num,
  input  logic [31:0]            den,
  input  logic [TAG_W-1:0]       tag_in,
  output logic                   out_valid,
  output logic [LANES-1:0][31:0] quo,
  output logic [TAG_W-1:0]       tag_out
);

  localparam int NB = 32 + FRAC_BITS;

  logic [NB:0]                      v_r;
  logic [31:0]                      d_r   [NB+1];
  logic [TAG_W-1:0]                 tag_r [NB+1];
  logic [LANES-1:0]                 neg_r [NB+1];
  logic [LANES-1:0][NB-1:0]         n_r   [NB+1];
  logic [LANES-1:0][NB-1:0]         q_r   [NB+1];
  logic [LANES-1:0][31:0]           rem_r [NB+1];
  logic [LANES-1:0][31:0]           rem_nxt [NB];
  logic [LANES-1:0]                 qb    [NB];
  logic [LANES-1:0][31:0]           quo_nxt;
  logic [LANES-1:0][31:0]           quo_r;
  logic [LANES-1:0][31:0]           mag;
  logic [TAG_W-1:0]                 tag_out_r;
  logic                             out_valid_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = num[l][31] ? (~num[l] + 32'd1) : num[l];
    end
  end

  // trial subtract for every stage
  always_comb begin
    logic [32:0] trial;
    for (int k = 0; k < NB; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_r[k][l], n_r[k][l][NB-1]};
        qb[k][l] = (trial >= {1'b0, d_r[k]});
        rem_nxt[k][l] = qb[k][l] ? 32'(trial - {1'b0, d_r[k]}) : trial[31:0];
      end
    end
  end

  // saturate the final magnitude back to signed 32 bits
  always_comb begin
    logic big;
    for (int l = 0; l < LANES; l++) begin
      big = |q_r[NB][l][NB-1:31];
      if (neg_r[NB][l]) begin
        quo_nxt[l] = big ? 32'h8000_0000 : (~q_r[NB][l][31:0] + 32'd1);
      end else begin
        quo_nxt[l] = big ? 32'h7fff_ffff : q_r[NB][l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NB-1:0], in_valid};
      out_valid_r <= v_r[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]   <= den;
      tag_r[0] <= tag_in;
      for (int l = 0; l < LANES; l++) begin
        neg_r[0][l] <= num[l][31];
        n_r[0][l]   <= {mag[l], {FRAC_BITS{1'b0}}};
        q_r[0][l]   <= '0;
        rem_r[0][l] <= '0;
      end
      for (int k = 0; k < NB; k++) begin
        d_r[k+1]   <= d_r[k];
        tag_r[k+1] <= tag_r[k];
        neg_r[k+1] <= neg_r[k];
        for (int l = 0; l < LANES; l++) begin
          n_r[k+1][l]   <= {n_r[k][l][NB-2:0], 1'b0};
          q_r[k+1][l]   <= {q_r[k][l][NB-2:0], qb[k][l]};
          rem_r[k+1][l] <= rem_nxt[k][l];
        end
      end
      quo_r     <= quo_nxt;
      tag_out_r <= tag_r[NB];
    end
  end

  assign out_valid = out_valid_r;
  assign quo       = quo_r;
  assign tag_out   = tag_out_r;

endmodule

// File: rtl/ldlt_solve_3x3_top.sv
// Top level of the 3x3 LDL^T solver: factorisation, substitutions, result register.
// Depends on lds_pkg and lds_div.
//
// Usage
//   Input channel in_valid/in_ready/in_data carries one word per system: the lower
//   triangle of a symmetric matrix and the right-hand side, all signed Q format
//   with FRAC_BITS fraction bits. Result channel out_valid/out_ready/out_data
//   returns one word per system: the solution, saturated, and bad_pivot.
//   A pivot that is zero or negative sets bad_pivot and zeroes the solution.
// Throughput: one word per cycle while the receiver keeps taking results.
// Pipeline: three bit-per-stage dividers in turn, pivot d0, then d1, then d2,
//   each 32+FRAC_BITS+2 deep, with three multiply/subtract stages after each
//   and the result register.
// Stall: the whole pipeline holds while a result waits unaccepted; in_ready
//   then drops, nothing is lost or repeated. Bubbles still drain while the
//   result register is empty.
// Reset: rst_n (synchronous, active low) clears every valid bit; data registers
//   keep whatever they hold. No state is carried between systems.
module ldlt_solve_3x3_top
  import lds_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  typedef struct packed {
    q_t a11; q_t a21; q_t a22; q_t b0; q_t b1; q_t b2; q_t d0; logic bad;
  } tag_a_t;
  typedef struct packed {
    q_t m1; q_t m2; q_t m3; q_t m4; q_t m5; q_t l10; q_t l20; q_t z0; q_t d0;
    q_t a11; q_t a21; q_t a22; q_t b1; q_t b2; logic bad;
  } s1_t;
  typedef struct packed {
    q_t n1; q_t n2; q_t n3; q_t y1; q_t y2p; q_t l10; q_t l20; q_t z0;
    q_t a11; q_t a21; q_t a22; logic bad;
  } s2_t;
  typedef struct packed {
    q_t d1; q_t num21; q_t t; q_t y1; q_t y2p; q_t l10; q_t l20; q_t z0; logic bad;
  } s3_t;
  typedef struct packed {
    q_t y1; q_t y2p; q_t t; q_t d1; q_t l10; q_t l20; q_t z0; logic bad;
  } tag_b_t;
  typedef struct packed {
    q_t m6; q_t m7; q_t y2p; q_t t; q_t d1; q_t l10; q_t l20; q_t z0; q_t z1;
    q_t l21; logic bad;
  } s4_t;
  typedef struct packed {
    q_t m8; q_t y2; q_t t; q_t l10; q_t l20; q_t z0; q_t z1; q_t l21; logic bad;
  } s5_t;
  typedef struct packed {
    q_t d2; q_t y2; q_t l10; q_t l20; q_t z0; q_t z1; q_t l21; logic bad;
  } s6_t;
  typedef struct packed {
    q_t l10; q_t l20; q_t z0; q_t z1; q_t l21; logic bad;
  } tag_c_t;
  typedef struct packed {
    q_t m9; q_t x2; q_t l10; q_t l20; q_t z0; q_t z1; logic bad;
  } s7_t;
  typedef struct packed {
    q_t x1; q_t x2; q_t l10; q_t l20; q_t z0; logic bad;
  } s8_t;
  typedef struct packed {
    q_t m10; q_t m11; q_t z0; q_t x1; q_t x2; logic bad;
  } s9_t;

  logic adv;

  // divider A: l10, l20, z0 against pivot d0
  tag_a_t          tag_a_in, tag_a_out;
  logic [2:0][31:0] qa;
  logic            va;
  // divider B: l21, z1 against pivot d1
  tag_b_t          tag_b_in, tag_b_out;
  logic [1:0][31:0] qb;
  logic            vb;
  // divider C: z2 against pivot d2
  tag_c_t          tag_c_in, tag_c_out;
  logic [0:0][31:0] qc;
  logic            vc;

  s1_t s1_nxt, s1_r;
  s2_t s2_nxt, s2_r;
  s3_t s3_nxt, s3_r;
  s4_t s4_nxt, s4_r;
  s5_t s5_nxt, s5_r;
  s6_t s6_nxt, s6_r;
  s7_t s7_nxt, s7_r;
  s8_t s8_nxt, s8_r;
  s9_t s9_nxt, s9_r;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r;
  out_word_t out_nxt, out_r;
  logic      out_valid_r;

  // advance everything unless a finished word is held up at the output
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    tag_a_in.a11 = in_data.a11;
    tag_a_in.a21 = in_data.a21;
    tag_a_in.a22 = in_data.a22;
    tag_a_in.b0  = in_data.rhs0;
    tag_a_in.b1  = in_data.rhs1;
    tag_a_in.b2  = in_data.rhs2;
    tag_a_in.d0  = in_data.a00;
    tag_a_in.bad = (in_data.a00 <= 32'sd0);
  end

  lds_div #(.FRAC_BITS(FRAC_BITS), .LANES(3), .TAG_W($bits(tag_a_t))) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .num      ({in_data.rhs0, in_data.a20, in_data.a10}),
    .den      (in_data.a00),
    .tag_in   (tag_a_in),
    .out_valid(va),
    .quo      (qa),
    .tag_out  (tag_a_out)
  );

  // stage 1: first-level products of the factors
  always_comb begin
    s1_nxt.l10 = q_t'(qa[0]);
    s1_nxt.l20 = q_t'(qa[1]);
    s1_nxt.z0  = q_t'(qa[2]);
    s1_nxt.m1  = qmul(s1_nxt.l10, s1_nxt.l10, FRAC_BITS);
    s1_nxt.m2  = qmul(s1_nxt.l20, s1_nxt.l10, FRAC_BITS);
    s1_nxt.m3  = qmul(s1_nxt.l20, s1_nxt.l20, FRAC_BITS);
    s1_nxt.m4  = qmul(s1_nxt.l10, tag_a_out.b0, FRAC_BITS);
    s1_nxt.m5  = qmul(s1_nxt.l20, tag_a_out.b0, FRAC_BITS);
    s1_nxt.d0  = tag_a_out.d0;
    s1_nxt.a11 = tag_a_out.a11;
    s1_nxt.a21 = tag_a_out.a21;
    s1_nxt.a22 = tag_a_out.a22;
    s1_nxt.b1  = tag_a_out.b1;
    s1_nxt.b2  = tag_a_out.b2;
    s1_nxt.bad = tag_a_out.bad;
  end

  // stage 2: scale by d0, start forward substitution
  always_comb begin
    s2_nxt.n1  = qmul(s1_r.m1, s1_r.d0, FRAC_BITS);
    s2_nxt.n2  = qmul(s1_r.m2, s1_r.d0, FRAC_BITS);
    s2_nxt.n3  = qmul(s1_r.m3, s1_r.d0, FRAC_BITS);
    s2_nxt.y1  = qsub(s1_r.b1, s1_r.m4);
    s2_nxt.y2p = qsub(s1_r.b2, s1_r.m5);
    s2_nxt.l10 = s1_r.l10;
    s2_nxt.l20 = s1_r.l20;
    s2_nxt.z0  = s1_r.z0;
    s2_nxt.a11 = s1_r.a11;
    s2_nxt.a21 = s1_r.a21;
    s2_nxt.a22 = s1_r.a22;
    s2_nxt.bad = s1_r.bad;
  end

  // stage 3: pivot d1 and its check
  always_comb begin
    s3_nxt.d1    = qsub(s2_r.a11, s2_r.n1);
    s3_nxt.num21 = qsub(s2_r.a21, s2_r.n2);
    s3_nxt.t     = qsub(s2_r.a22, s2_r.n3);
    s3_nxt.y1    = s2_r.y1;
    s3_nxt.y2p   = s2_r.y2p;
    s3_nxt.l10   = s2_r.l10;
    s3_nxt.l20   = s2_r.l20;
    s3_nxt.z0    = s2_r.z0;
    s3_nxt.bad   = s2_r.bad || (s3_nxt.d1 <= 32'sd0);
  end

  always_comb begin
    tag_b_in.y1  = s3_r.y1;
    tag_b_in.y2p = s3_r.y2p;
    tag_b_in.t   = s3_r.t;
    tag_b_in.d1  = s3_r.d1;
    tag_b_in.l10 = s3_r.l10;
    tag_b_in.l20 = s3_r.l20;
    tag_b_in.z0  = s3_r.z0;
    tag_b_in.bad = s3_r.bad;
  end

  lds_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .TAG_W($bits(tag_b_t))) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s3_v_r),
    .num      ({s3_r.y1, s3_r.num21}),
    .den      (s3_r.d1),
    .tag_in   (tag_b_in),
    .out_valid(vb),
    .quo      (qb),
    .tag_out  (tag_b_out)
  );

  // stage 4: products of l21
  always_comb begin
    s4_nxt.l21 = q_t'(qb[0]);
    s4_nxt.z1  = q_t'(qb[1]);
    s4_nxt.m6  = qmul(s4_nxt.l21, s4_nxt.l21, FRAC_BITS);
    s4_nxt.m7  = qmul(s4_nxt.l21, tag_b_out.y1, FRAC_BITS);
    s4_nxt.y2p = tag_b_out.y2p;
    s4_nxt.t   = tag_b_out.t;
    s4_nxt.d1  = tag_b_out.d1;
    s4_nxt.l10 = tag_b_out.l10;
    s4_nxt.l20 = tag_b_out.l20;
    s4_nxt.z0  = tag_b_out.z0;
    s4_nxt.bad = tag_b_out.bad;
  end

  // stage 5: scale by d1, finish y2
  always_comb begin
    s5_nxt.m8  = qmul(s4_r.m6, s4_r.d1, FRAC_BITS);
    s5_nxt.y2  = qsub(s4_r.y2p, s4_r.m7);
    s5_nxt.t   = s4_r.t;
    s5_nxt.l10 = s4_r.l10;
    s5_nxt.l20 = s4_r.l20;
    s5_nxt.z0  = s4_r.z0;
    s5_nxt.z1  = s4_r.z1;
    s5_nxt.l21 = s4_r.l21;
    s5_nxt.bad = s4_r.bad;
  end

  // stage 6: pivot d2 and its check
  always_comb begin
    s6_nxt.d2  = qsub(s5_r.t, s5_r.m8);
    s6_nxt.y2  = s5_r.y2;
    s6_nxt.l10 = s5_r.l10;
    s6_nxt.l20 = s5_r.l20;
    s6_nxt.z0  = s5_r.z0;
    s6_nxt.z1  = s5_r.z1;
    s6_nxt.l21 = s5_r.l21;
    s6_nxt.bad = s5_r.bad || (s6_nxt.d2 <= 32'sd0);
  end

  always_comb begin
    tag_c_in.l10 = s6_r.l10;
    tag_c_in.l20 = s6_r.l20;
    tag_c_in.z0  = s6_r.z0;
    tag_c_in.z1  = s6_r.z1;
    tag_c_in.l21 = s6_r.l21;
    tag_c_in.bad = s6_r.bad;
  end

  lds_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .TAG_W($bits(tag_c_t))) u_div_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s6_v_r),
    .num      (s6_r.y2),
    .den      (s6_r.d2),
    .tag_in   (tag_c_in),
    .out_valid(vc),
    .quo      (qc),
    .tag_out  (tag_c_out)
  );

  // stage 7: back substitution, x2 times l21
  always_comb begin
    s7_nxt.x2  = q_t'(qc[0]);
    s7_nxt.m9  = qmul(tag_c_out.l21, s7_nxt.x2, FRAC_BITS);
    s7_nxt.l10 = tag_c_out.l10;
    s7_nxt.l20 = tag_c_out.l20;
    s7_nxt.z0  = tag_c_out.z0;
    s7_nxt.z1  = tag_c_out.z1;
    s7_nxt.bad = tag_c_out.bad;
  end

  // stage 8: x1
  always_comb begin
    s8_nxt.x1  = qsub(s7_r.z1, s7_r.m9);
    s8_nxt.x2  = s7_r.x2;
    s8_nxt.l10 = s7_r.l10;
    s8_nxt.l20 = s7_r.l20;
    s8_nxt.z0  = s7_r.z0;
    s8_nxt.bad = s7_r.bad;
  end

  // stage 9: last products
  always_comb begin
    s9_nxt.m10 = qmul(s8_r.l10, s8_r.x1, FRAC_BITS);
    s9_nxt.m11 = qmul(s8_r.l20, s8_r.x2, FRAC_BITS);
    s9_nxt.z0  = s8_r.z0;
    s9_nxt.x1  = s8_r.x1;
    s9_nxt.x2  = s8_r.x2;
    s9_nxt.bad = s8_r.bad;
  end

  // result: x0, then drop the solution on a bad pivot
  always_comb begin
    out_nxt.sol0      = qsub(qsub(s9_r.z0, s9_r.m10), s9_r.m11);
    out_nxt.sol1      = s9_r.x1;
    out_nxt.sol2      = s9_r.x2;
    out_nxt.bad_pivot = s9_r.bad;
    if (s9_r.bad) begin
      out_nxt.sol0 = '0;
      out_nxt.sol1 = '0;
      out_nxt.sol2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      s9_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= va;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= vb;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      s7_v_r      <= vc;
      s8_v_r      <= s7_v_r;
      s9_v_r      <= s8_v_r;
      out_valid_r <= s9_v_r;
    end
  end

  // payload holds with the valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      s5_r  <= s5_nxt;
      s6_r  <= s6_nxt;
      s7_r  <= s7_nxt;
      s8_r  <= s8_nxt;
      s9_r  <= s9_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
